// ===== rtl/core/trcu_pkg.sv =====
// shared types and constants for the ring-road car update block
package trcu_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int SPEED_BITS     = 8;
   localparam int RING_BITS      = 31;
   localparam int PROB_BITS      = 17;
   localparam int FRACTION_SHIFT = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RING_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DAWDLE_PROB = 2'd2;

   localparam logic [RING_BITS-1:0]  RING_LENGTH_RESET = 31'd1000;
   localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET   = 8'd5;
   localparam logic [PROB_BITS-1:0]  DAWDLE_PROB_RESET = 17'd16384;

   typedef struct packed {
      logic [RING_BITS-1:0]  ring_length;
      logic [SPEED_BITS-1:0] max_speed;
      logic [PROB_BITS-1:0]  dawdle_prob;
   } cfg_type;

endpackage

// ===== rtl/core/traffic_ring_car_update.sv =====
// ring-road car update: a car's job is queued as its successor is taken; its result
// passes the queue and the result register, and a step's closing job is issued after
// its last car is taken. Throughput is one car per cycle, set by the update stage,
// unless the output stalls; a last car holds input while its closing job is issued.
// reset: ring_length 1000, max_speed 5, dawdle_prob 16384, no car held, queue empty,
// result register empty.
module traffic_ring_car_update #(
   parameter int POSITION_BITS = 32,
   parameter int RANDOM_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // position, speed, random_fraction, zero fill
   input  logic [((POSITION_BITS+trcu_pkg::SPEED_BITS+RANDOM_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // new_position, new_speed, zero fill
   output logic [((POSITION_BITS+trcu_pkg::SPEED_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [trcu_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [trcu_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SB       = trcu_pkg::SPEED_BITS;
   localparam int RSP_BITS = ((POSITION_BITS + SB + 7) / 8) * 8;
   localparam int JOB_BITS = 2 * POSITION_BITS + SB + RANDOM_BITS + 1;

   trcu_pkg::cfg_type cfg_ff, cfg_in;

   logic                     job_valid, job_ready, head_valid, head_ready;
   logic [JOB_BITS-1:0]      job_data, head_data;
   logic [POSITION_BITS-1:0] out_position;
   logic [SB-1:0]            out_speed;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            trcu_pkg::CSR_RING_LENGTH:
               cfg_in.ring_length = csr_data[trcu_pkg::RING_BITS-1:0];
            trcu_pkg::CSR_MAX_SPEED:
               cfg_in.max_speed = csr_data[SB-1:0];
            trcu_pkg::CSR_DAWDLE_PROB:
               cfg_in.dawdle_prob = csr_data[trcu_pkg::PROB_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_length <= trcu_pkg::RING_LENGTH_RESET;
         cfg_ff.max_speed   <= trcu_pkg::MAX_SPEED_RESET;
         cfg_ff.dawdle_prob <= trcu_pkg::DAWDLE_PROB_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trcu_front #(
      .POSITION_BITS(POSITION_BITS),
      .RANDOM_BITS  (RANDOM_BITS),
      .JOB_BITS     (JOB_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_position(req_tdata[POSITION_BITS-1:0]),
      .in_speed   (req_tdata[POSITION_BITS+SB-1:POSITION_BITS]),
      .in_random  (req_tdata[POSITION_BITS+SB+RANDOM_BITS-1:POSITION_BITS+SB]),
      .in_last    (req_tlast),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job_data   (job_data)
   );

   trcu_queue #(
      .WIDTH(JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(job_valid),
      .push_ready(job_ready),
      .push_data (job_data),
      .pop_valid (head_valid),
      .pop_ready (head_ready),
      .pop_data  (head_data)
   );

   trcu_back #(
      .POSITION_BITS(POSITION_BITS),
      .RANDOM_BITS  (RANDOM_BITS),
      .JOB_BITS     (JOB_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job_valid   (head_valid),
      .job_ready   (head_ready),
      .job_data    (head_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_position(out_position),
      .out_speed   (out_speed),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({out_speed, out_position});

endmodule

// ===== rtl/core/trcu_front.sv =====
// front end: takes cars, holds each until its successor arrives, issues update jobs
module trcu_front #(
   parameter int POSITION_BITS = 32,
   parameter int RANDOM_BITS   = 16,
   parameter int JOB_BITS      = 2 * POSITION_BITS + trcu_pkg::SPEED_BITS + RANDOM_BITS + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  trcu_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [POSITION_BITS-1:0]          in_position,
   input  logic [trcu_pkg::SPEED_BITS-1:0]   in_speed,
   input  logic [RANDOM_BITS-1:0]            in_random,
   input  logic                              in_last,
   output logic                              job_valid,
   input  logic                              job_ready,
   output logic [JOB_BITS-1:0]               job_data
);

   logic                            held_ff, held_in;
   logic                            flush_ff, flush_in;
   logic [POSITION_BITS-1:0]        first_ff, first_in;
   logic [POSITION_BITS-1:0]        hpos_ff, hpos_in;
   logic [trcu_pkg::SPEED_BITS-1:0] hspd_ff, hspd_in;
   logic [RANDOM_BITS-1:0]          hrnd_ff, hrnd_in;

   logic                            accept;
   logic [POSITION_BITS+trcu_pkg::RING_BITS-1:0] ring_wide;
   logic [POSITION_BITS-1:0]        ahead;
   logic [POSITION_BITS-1:0]        gap;

   assign in_ready  = !flush_ff && job_ready;
   assign accept    = in_valid && in_ready;
   assign ring_wide = {{POSITION_BITS{1'b0}}, cfg.ring_length};

   // car ahead: the new car, or the first car one lap on when the step closes
   assign ahead = flush_ff ? first_ff + ring_wide[POSITION_BITS-1:0] : in_position;
   assign gap   = ahead - hpos_ff;

   assign job_valid = flush_ff || (accept && held_ff);
   assign job_data  = {flush_ff, gap, hrnd_ff, hspd_ff, hpos_ff};

   always_comb begin
      held_in  = held_ff;
      flush_in = flush_ff;
      first_in = first_ff;
      hpos_in  = hpos_ff;
      hspd_in  = hspd_ff;
      hrnd_in  = hrnd_ff;
      if (flush_ff && job_ready) begin
         held_in  = 1'b0;
         flush_in = 1'b0;
      end else if (accept) begin
         if (!held_ff) begin
            first_in = in_position;
         end
         held_in  = 1'b1;
         flush_in = in_last;
         hpos_in  = in_position;
         hspd_in  = in_speed;
         hrnd_in  = in_random;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         flush_ff <= 1'b0;
         first_ff <= '0;
      end else begin
         held_ff  <= held_in;
         flush_ff <= flush_in;
         first_ff <= first_in;
      end
      hpos_ff <= hpos_in;
      hspd_ff <= hspd_in;
      hrnd_ff <= hrnd_in;
   end

endmodule

// ===== rtl/core/trcu_queue.sv =====
// small register queue between the front end and the update stage
module trcu_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH     = 4;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/trcu_back.sv =====
// update stage: speed rule, dawdle and advance, into the result register
module trcu_back #(
   parameter int POSITION_BITS = 32,
   parameter int RANDOM_BITS   = 16,
   parameter int JOB_BITS      = 2 * POSITION_BITS + trcu_pkg::SPEED_BITS + RANDOM_BITS + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  trcu_pkg::cfg_type               cfg,
   input  logic                            job_valid,
   output logic                            job_ready,
   input  logic [JOB_BITS-1:0]             job_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [POSITION_BITS-1:0]        out_position,
   output logic [trcu_pkg::SPEED_BITS-1:0] out_speed,
   output logic                            out_last
);

   localparam int SB = trcu_pkg::SPEED_BITS;
   localparam int CMP_BITS = RANDOM_BITS + trcu_pkg::PROB_BITS;

   logic [POSITION_BITS-1:0] pos, gap, room;
   logic [SB-1:0]            spd;
   logic [RANDOM_BITS-1:0]   rnd;
   logic                     last;
   logic [SB:0]              v_inc, v_lim;
   logic [SB-1:0]            v_room, v_new;
   logic [CMP_BITS-1:0]      draw_scaled, prob_scaled;
   logic                     load;

   logic                     valid_ff, valid_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [SB-1:0]            spd_ff, spd_in;
   logic                     last_ff, last_in;

   assign {last, gap, rnd, spd, pos} = job_data;

   // a gap of zero or less, read as signed, leaves no room
   assign room  = (gap == '0 || gap[POSITION_BITS-1]) ? '0 : gap - 1'b1;
   assign v_inc = {1'b0, spd} + 1'b1;
   assign v_lim = (v_inc > {1'b0, cfg.max_speed}) ? {1'b0, cfg.max_speed} : v_inc;
   assign v_room = (POSITION_BITS'(v_lim) > room) ? room[SB-1:0] : v_lim[SB-1:0];

   assign draw_scaled = {1'b0, rnd, {trcu_pkg::FRACTION_SHIFT{1'b0}}};
   assign prob_scaled = {cfg.dawdle_prob, {RANDOM_BITS{1'b0}}};
   assign v_new = (draw_scaled < prob_scaled && v_room != '0) ? v_room - 1'b1 : v_room;

   assign load      = job_valid && (!valid_ff || out_ready);
   assign job_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      spd_in   = spd_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = pos + POSITION_BITS'(v_new);
         spd_in   = v_new;
         last_in  = last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pos_ff  <= pos_in;
      spd_ff  <= spd_in;
      last_ff <= last_in;
   end

   assign out_valid    = valid_ff;
   assign out_position = pos_ff;
   assign out_speed    = spd_ff;
   assign out_last     = last_ff;

endmodule

// ===== sim/tb_traffic_ring_car_update.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the ring-road car update block
module tb_traffic_ring_car_update;

   localparam int POSITION_BITS  = 32;
   localparam int RANDOM_BITS    = 16;
   localparam int SPEED_BITS     = trcu_pkg::SPEED_BITS;
   localparam int RING_BITS      = trcu_pkg::RING_BITS;
   localparam int PROB_BITS      = trcu_pkg::PROB_BITS;
   localparam int FRACTION_SHIFT = trcu_pkg::FRACTION_SHIFT;
   localparam int CSR_INDEX_BITS = trcu_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = trcu_pkg::CSR_DATA_BITS;
   localparam int REQ_BITS      = ((POSITION_BITS + SPEED_BITS + RANDOM_BITS + 7) / 8) * 8;
   localparam int RSP_BITS      = ((POSITION_BITS + SPEED_BITS + 7) / 8) * 8;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int PHASE_ITEMS   = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic [SPEED_BITS-1:0]    speed;
      logic                     end_of_step;
   } car_result_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata  = '0;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // shadow of the block's registers and of the car waiting for its successor
   trcu_pkg::cfg_type settings = '{ring_length: trcu_pkg::RING_LENGTH_RESET,
                                   max_speed: trcu_pkg::MAX_SPEED_RESET,
                                   dawdle_prob: trcu_pkg::DAWDLE_PROB_RESET};
   logic [POSITION_BITS-1:0] step_start_pos = '0;
   logic [POSITION_BITS-1:0] waiting_pos    = '0;
   logic [SPEED_BITS-1:0]    waiting_speed  = '0;
   logic [RANDOM_BITS-1:0]   waiting_draw   = '0;
   logic                     car_waiting    = 1'b0;
   car_result_type           expected_cars[$];

   int mismatches = 0;
   int cars_sent  = 0;
   bit no_idle    = 1'b0;
   int hold_order = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   traffic_ring_car_update #(
      .POSITION_BITS(POSITION_BITS),
      .RANDOM_BITS  (RANDOM_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("traffic_ring_car_update verification failed");
      $finish;
   end

   // one car's new speed and position, given the wrapped distance to the car ahead
   function automatic car_result_type move_car(input logic [POSITION_BITS-1:0] pos,
                                               input logic [SPEED_BITS-1:0] spd,
                                               input logic [RANDOM_BITS-1:0] draw,
                                               input logic [POSITION_BITS-1:0] gap,
                                               input logic last);
      logic [POSITION_BITS-1:0] room;
      logic [POSITION_BITS-1:0] v;
      car_result_type           r;
      room = (gap == '0 || gap[POSITION_BITS-1]) ? '0 : gap - 1'b1;
      v = POSITION_BITS'(spd) + 1;
      if (v > POSITION_BITS'(settings.max_speed)) v = POSITION_BITS'(settings.max_speed);
      if (v > room) v = room;
      // draw and probability brought to the same scale before the compare
      if ((64'(draw) << FRACTION_SHIFT) < (64'(settings.dawdle_prob) << RANDOM_BITS) && v != 0)
         v = v - 1;
      r.position    = pos + v;
      r.speed       = v[SPEED_BITS-1:0];
      r.end_of_step = last;
      return r;
   endfunction

   function automatic void predict_car(input logic [POSITION_BITS-1:0] pos,
                                       input logic [SPEED_BITS-1:0] spd,
                                       input logic [RANDOM_BITS-1:0] draw,
                                       input logic last);
      if (car_waiting)
         expected_cars.push_back(move_car(waiting_pos, waiting_speed, waiting_draw,
                                          pos - waiting_pos, 1'b0));
      else
         step_start_pos = pos;
      if (last) begin
         expected_cars.push_back(move_car(pos, spd, draw,
                                          step_start_pos + settings.ring_length - pos, 1'b1));
         car_waiting = 1'b0;
      end else begin
         waiting_pos   = pos;
         waiting_speed = spd;
         waiting_draw  = draw;
         car_waiting   = 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
   endtask

   task automatic send_car(input logic [POSITION_BITS-1:0] pos,
                           input logic [SPEED_BITS-1:0] spd,
                           input logic [RANDOM_BITS-1:0] draw,
                           input logic last);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'({draw, spd, pos});
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_car(pos, spd, draw, last);
      cars_sent++;
   endtask

   // pause the car stream until every pending result is out and the pipe is quiet
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_cars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [RING_BITS-1:0] ring,
                                 input logic [SPEED_BITS-1:0] top_speed,
                                 input logic [PROB_BITS-1:0] prob);
      logic [CSR_INDEX_BITS-1:0] regs [3];
      logic [CSR_DATA_BITS-1:0]  words [3];
      regs = '{trcu_pkg::CSR_RING_LENGTH, trcu_pkg::CSR_MAX_SPEED, trcu_pkg::CSR_DAWDLE_PROB};
      // bits above each register's width carry junk
      words[0] = {1'($urandom), ring};
      words[1] = {24'($urandom), top_speed};
      words[2] = {15'($urandom), prob};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[k];
         csr_data  <= words[k];
         do @(posedge clock); while (!csr_ready);
         case (regs[k])
            trcu_pkg::CSR_RING_LENGTH: settings.ring_length = words[k][RING_BITS-1:0];
            trcu_pkg::CSR_MAX_SPEED:   settings.max_speed   = words[k][SPEED_BITS-1:0];
            trcu_pkg::CSR_DAWDLE_PROB: settings.dawdle_prob = words[k][PROB_BITS-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // single cars that are first and last at once, at both ends of the position range
   task automatic test_single_cars();
      send_car(32'd0, 8'd0, 16'd0, 1'b1);
      send_car(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1);
      wait_for_drain();
   endtask

   // gap of one, zero and negative, and the last car's gap around the ring
   task automatic test_gaps_and_order();
      send_car(32'd100, 8'd3, 16'hFFFF, 1'b0);
      send_car(32'd104, 8'd3, 16'hFFFF, 1'b0);
      send_car(32'd105, 8'd4, 16'h0000, 1'b0);
      send_car(32'd105, 8'd0, 16'h8000, 1'b0);
      send_car(32'd90, 8'd2, 16'h3FFF, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_extreme_settings();
      // zero ring length: the last gap is the signed distance to the first car
      write_settings(31'd0, 8'hFF, 17'd0);
      send_car(32'd10, 8'hFF, 16'd0, 1'b0);
      send_car(32'd600, 8'd7, 16'd0, 1'b1);
      wait_for_drain();
      // probability of one always slows a moving car
      write_settings(31'h7FFF_FFFF, 8'hFF, 17'd65536);
      send_car(32'hFFFF_FFF0, 8'd200, 16'hFFFF, 1'b1);
      wait_for_drain();
      write_settings(31'd1, 8'd0, 17'h1FFFF);
      send_car(32'd5, 8'd9, 16'hFFFF, 1'b0);
      send_car(32'd9, 8'd1, 16'd0, 1'b1);
      wait_for_drain();
   endtask

   // a held car is computed with the settings in force when its successor arrives
   task automatic test_midstep_settings();
      write_settings(31'd1000, 8'd5, 17'd16384);
      send_car(32'd20, 8'd4, 16'h1000, 1'b0);
      wait_for_drain();
      write_settings(31'd50, 8'd2, 17'd0);
      send_car(32'd30, 8'd1, 16'hFFFF, 1'b1);
      wait_for_drain();
   endtask

   // mostly ordered steps with small gaps, some junk cars and broken steps
   task automatic send_random_step();
      int                       cars;
      bit                       tidy;
      logic [POSITION_BITS-1:0] start;
      logic [POSITION_BITS-1:0] pos;
      logic [SPEED_BITS-1:0]    spd;
      logic                     last;
      cars  = $urandom_range(1, 8);
      tidy  = ($urandom_range(99) < 85);
      start = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(20) : $urandom;
      pos   = start;
      for (int k = 0; k < cars; k++) begin
         last = (k == cars - 1);
         if (!tidy) begin
            pos  = $urandom;
            spd  = SPEED_BITS'($urandom);
            last = ($urandom_range(3) == 0);
         end else begin
            if (k != 0) begin
               if (last && $urandom_range(1))
                  pos = start + settings.ring_length
                        - $urandom_range(0, settings.max_speed + 3);
               else
                  pos = pos + $urandom_range(0, settings.max_speed + 3);
            end
            spd = ($urandom_range(9) == 0) ? SPEED_BITS'($urandom)
                                           : SPEED_BITS'($urandom_range(0, settings.max_speed + 2));
         end
         send_car(pos, spd, RANDOM_BITS'($urandom), last);
      end
   endtask

   task automatic test_random_steps();
      int                    goal;
      int                    phase;
      int                    phase_start;
      logic [RING_BITS-1:0]  ring;
      logic [SPEED_BITS-1:0] top_speed;
      logic [PROB_BITS-1:0]  prob;
      goal  = cars_sent + RANDOM_ITEMS;
      phase = 0;
      while (cars_sent < goal) begin
         wait_for_drain();
         if (phase == 0) begin
            write_settings(31'd1, 8'd0, 17'd0);
         end else if (phase == 1) begin
            write_settings(31'h7FFF_FFFF, 8'hFF, 17'd65536);
         end else begin
            ring      = ($urandom_range(3) == 0) ? RING_BITS'($urandom)
                                                 : RING_BITS'($urandom_range(1, 200));
            top_speed = ($urandom_range(3) == 0) ? SPEED_BITS'($urandom)
                                                 : SPEED_BITS'($urandom_range(1, 10));
            if ($urandom_range(4) == 0)
               prob = $urandom_range(1) ? 17'd65536 : 17'd0;
            else
               prob = PROB_BITS'($urandom_range(0, 65536));
            write_settings(ring, top_speed, prob);
         end
         no_idle = (phase == 3);
         // long receiver stall while cars keep coming
         if (phase == 5) hold_order <= hold_order + 1;
         phase_start = cars_sent;
         while (cars_sent - phase_start < PHASE_ITEMS) send_random_step();
         phase++;
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_order != hold_seen) begin
         hold_seen = hold_order;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   // compare each result transfer with the oldest pending car
   always @(posedge clock) begin
      car_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cars.size() == 0) begin
            report_mismatch("result with no car pending", '0, 64'(rsp_tdata));
         end else begin
            want = expected_cars.pop_front();
            if (rsp_tdata[POSITION_BITS-1:0] !== want.position)
               report_mismatch("new_position", 64'(want.position),
                               64'(rsp_tdata[POSITION_BITS-1:0]));
            if (rsp_tdata[POSITION_BITS +: SPEED_BITS] !== want.speed)
               report_mismatch("new_speed", 64'(want.speed),
                               64'(rsp_tdata[POSITION_BITS +: SPEED_BITS]));
            if (rsp_tlast !== want.end_of_step)
               report_mismatch("end_of_step", 64'(want.end_of_step), 64'(rsp_tlast));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_single_cars();
      test_gaps_and_order();
      test_extreme_settings();
      test_midstep_settings();
      test_random_steps();
      wait_for_drain();
      if (mismatches == 0) begin
         $display("traffic_ring_car_update verification clean");
      end else begin
         $display("traffic_ring_car_update verification failed");
      end
      $finish;
   end

endmodule
